[rtl/core/glj_pkg.sv]
package glj_pkg;

  localparam int LEN_W = 5;
  localparam logic [LEN_W-1:0] LEN_RESET = 5'd31;

  localparam logic [7:0] SEP_BYTE = 8'd32;
  localparam logic [7:0] NL_BYTE  = 8'd10;
  localparam logic [7:0] NUL_BYTE = 8'd0;

  localparam int MAX_RESULTS = 64;
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    EMIT_CHAR  = 2'd0,
    EMIT_SPACE = 2'd1,
    EMIT_NL    = 2'd2
  } emit_sel_t;

  typedef struct packed {
    logic      load_in;
    logic      char_step;
    logic      add_word;
    logic      fsetup;
    logic      div_step;
    logic      load_klen;
    logic      load_spc;
    logic      next_word;
    logic      emit;
    emit_sel_t emit_sel;
    logic      nl_final;
    logic      flush_done;
  } cmd_t;

  typedef struct packed {
    logic is_sep;
    logic is_end;
    logic open_zero;
    logic need_flush;
    logic held_zero;
    logic gaps_zero;
    logic div_done;
    logic word_last;
    logic kchar_last;
    logic spc_last;
    logic spc_calc_zero;
    logic emit_ok;
  } sts_t;

endpackage

[rtl/core/glj_ram.sv]
module glj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/glj_dp.sv]
module glj_dp import glj_pkg::*; #(
  parameter int WORD_MAX = 17,
  parameter int LINE_MAX = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  input  logic [7:0]       in_char,
  input  logic             end_of_text,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [7:0]       out_char,
  output logic             run_last
);

  localparam int DEPTH = LINE_MAX + WORD_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = AW + 2;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int NW    = CW + 2;
  localparam int WLD   = LINE_MAX / 2 + 2;
  localparam int WLAW  = $clog2(WLD);
  localparam int HW    = $clog2(WLD + 1);
  localparam int OW    = $clog2(WORD_MAX + 1);
  localparam int DCW   = $clog2(LEN_W + 1);

  // circular buffer: logical position x sits at bp + x
  function automatic logic [AW-1:0] circ(input logic [AW-1:0] b, input logic [CW-1:0] x);
    logic [PW-1:0] s;
    s = PW'(b) + PW'(x);
    if (s >= PW'(DEPTH)) begin
      s = s - PW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [LEN_W-1:0] line_length;
  logic [LEN_W-1:0] eff_len;
  logic [7:0]       chr;
  logic             end_r;
  logic [OW-1:0]    open_len;
  logic [HW-1:0]    held_words;
  logic [CW-1:0]    held_chars;
  logic [AW-1:0]    bp;
  logic [LEN_W-1:0] slack;
  logic [LEN_W-1:0] quo;
  logic [HW-1:0]    rem;
  logic [DCW-1:0]   div_cnt;
  logic [HW-1:0]    w;
  logic [CW-1:0]    pos;
  logic [OW-1:0]    kchar;
  logic [LEN_W:0]   spc;
  logic [RES_W-1:0] res_cnt;

  logic [HW-1:0]    gaps;
  logic [CW:0]      app_pos;
  logic             app_ok;
  logic [NW-1:0]    fit_sum;
  logic [NW-1:0]    slack_diff;
  logic [LEN_W-1:0] slack_calc;
  logic [LEN_W:0]   spc_calc;
  logic [HW:0]      rs;
  logic             ge;
  logic             cnt_full;
  logic [7:0]       emit_byte;
  logic             emit_last;

  logic             lr_we;
  logic [AW-1:0]    lr_waddr;
  logic [AW-1:0]    lr_raddr;
  logic [7:0]       lr_rdata;
  logic             wl_we;
  logic [OW-1:0]    wl_rdata;

  always_comb begin
    if (int'(line_length) > LINE_MAX) begin
      eff_len = LEN_W'(LINE_MAX);
    end else begin
      eff_len = line_length;
    end
  end

  assign gaps       = held_words - HW'(1);
  assign app_pos    = (CW+1)'(held_chars) + (CW+1)'(open_len);
  assign app_ok     = (chr != SEP_BYTE) && (chr != NUL_BYTE) &&
                      (open_len < OW'(WORD_MAX)) && (app_pos < (CW+1)'(DEPTH));
  assign fit_sum    = NW'(held_chars) + NW'(held_words) + NW'(open_len);
  assign slack_diff = NW'(eff_len) - NW'(held_chars);
  assign slack_calc = (NW'(eff_len) > NW'(held_chars)) ? slack_diff[LEN_W-1:0] : '0;
  assign rs         = {rem, quo[LEN_W-1]};
  assign ge         = rs >= (HW+1)'(gaps);
  assign cnt_full   = res_cnt >= RES_W'(MAX_RESULTS);

  always_comb begin
    if ((HW+1)'(w) + (HW+1)'(1) == (HW+1)'(held_words)) begin
      spc_calc = (held_words == HW'(1)) ? {1'b0, slack} : '0;
    end else begin
      spc_calc = (LEN_W+1)'(quo) + ((w < rem) ? (LEN_W+1)'(1) : '0);
    end
  end

  always_comb begin
    emit_last = 1'b0;
    case (cmd.emit_sel)
      EMIT_CHAR:  emit_byte = lr_rdata;
      EMIT_SPACE: emit_byte = SEP_BYTE;
      EMIT_NL: begin
        emit_byte = NL_BYTE;
        emit_last = cmd.nl_final;
      end
      default:    emit_byte = NL_BYTE;
    endcase
  end

  assign sts.is_sep        = chr == SEP_BYTE;
  assign sts.is_end        = end_r;
  assign sts.open_zero     = open_len == '0;
  assign sts.need_flush    = (held_words != '0) && (fit_sum > NW'(eff_len));
  assign sts.held_zero     = held_words == '0;
  assign sts.gaps_zero     = held_words == HW'(1);
  assign sts.div_done      = div_cnt == '0;
  assign sts.word_last     = (HW+1)'(w) + (HW+1)'(1) == (HW+1)'(held_words);
  assign sts.kchar_last    = kchar == OW'(1);
  assign sts.spc_last      = spc == (LEN_W+1)'(1);
  assign sts.spc_calc_zero = spc_calc == '0;
  assign sts.emit_ok       = cnt_full || !out_valid || !out_stall;

  assign lr_we    = cmd.char_step && app_ok;
  assign lr_waddr = circ(bp, app_pos[CW-1:0]);
  assign lr_raddr = circ(bp, pos);
  assign wl_we    = cmd.add_word && (held_words < HW'(WLD));

  glj_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (lr_we),
    .waddr (lr_waddr),
    .wdata (chr),
    .raddr (lr_raddr),
    .rdata (lr_rdata)
  );

  glj_ram #(.WIDTH(OW), .DEPTH(WLD)) u_wlen_ram (
    .clk   (clk),
    .we    (wl_we),
    .waddr (held_words[WLAW-1:0]),
    .wdata (open_len),
    .raddr (w[WLAW-1:0]),
    .rdata (wl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= LEN_RESET;
      open_len    <= '0;
      held_words  <= '0;
      held_chars  <= '0;
      bp          <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        line_length <= cfg_wr_data;
      end
      if (lr_we) begin
        open_len <= open_len + OW'(1);
      end
      if (cmd.add_word) begin
        if (held_words < HW'(WLD)) begin
          held_words <= held_words + HW'(1);
          held_chars <= held_chars + CW'(open_len);
        end
        open_len <= '0;
      end
      if (cmd.flush_done) begin
        bp         <= circ(bp, held_chars);
        held_words <= '0;
        held_chars <= '0;
      end
      if (cmd.emit && !cnt_full) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      chr     <= in_char;
      end_r   <= end_of_text;
      res_cnt <= '0;
    end
    if (cmd.fsetup) begin
      slack   <= slack_calc;
      quo     <= slack_calc;
      rem     <= '0;
      div_cnt <= DCW'(LEN_W);
      w       <= '0;
      pos     <= '0;
    end
    // restoring divide, one quotient bit per cycle
    if (cmd.div_step) begin
      rem     <= ge ? HW'(rs - (HW+1)'(gaps)) : HW'(rs);
      quo     <= {quo[LEN_W-2:0], ge};
      div_cnt <= div_cnt - DCW'(1);
    end
    if (cmd.load_klen) begin
      kchar <= wl_rdata;
    end
    if (cmd.load_spc) begin
      spc <= spc_calc;
    end
    if (cmd.next_word) begin
      w <= w + HW'(1);
    end
    if (cmd.emit) begin
      if (cmd.emit_sel == EMIT_CHAR) begin
        pos   <= pos + CW'(1);
        kchar <= kchar - OW'(1);
      end
      if (cmd.emit_sel == EMIT_SPACE) begin
        spc <= spc - (LEN_W+1)'(1);
      end
      if (!cnt_full) begin
        res_cnt  <= res_cnt + RES_W'(1);
        out_char <= emit_byte;
        run_last <= emit_last || (res_cnt == RES_W'(MAX_RESULTS - 1));
      end
    end
  end

endmodule

[rtl/core/glj_ctrl.sv]
module glj_ctrl import glj_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_CHAR   = 13'b0000000000010,
    S_CLOSE  = 13'b0000000000100,
    S_ADD    = 13'b0000000001000,
    S_FSETUP = 13'b0000000010000,
    S_DIV    = 13'b0000000100000,
    S_WREAD  = 13'b0000001000000,
    S_WLEN   = 13'b0000010000000,
    S_CREAD  = 13'b0000100000000,
    S_CEMIT  = 13'b0001000000000,
    S_GAP    = 13'b0010000000000,
    S_SEMIT  = 13'b0100000000000,
    S_NL     = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic   mode_add, mode_add_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next    = state;
    mode_add_next = mode_add;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CHAR;
        end
      end
      S_CHAR: begin
        cmd.char_step = 1'b1;
        state_next    = (sts.is_sep || sts.is_end) ? S_CLOSE : S_IDLE;
      end
      S_CLOSE: begin
        if (sts.open_zero) begin
          mode_add_next = 1'b0;
          state_next    = sts.is_end ? S_FSETUP : S_IDLE;
        end else if (sts.need_flush) begin
          mode_add_next = 1'b1;
          state_next    = S_FSETUP;
        end else begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_word  = 1'b1;
        mode_add_next = 1'b0;
        state_next    = sts.is_end ? S_FSETUP : S_IDLE;
      end
      S_FSETUP: begin
        if (sts.held_zero) begin
          state_next = mode_add ? S_ADD : S_IDLE;
        end else begin
          cmd.fsetup = 1'b1;
          state_next = sts.gaps_zero ? S_WREAD : S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_WREAD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_WREAD: begin
        state_next = S_WLEN;
      end
      S_WLEN: begin
        cmd.load_klen = 1'b1;
        state_next    = S_CREAD;
      end
      S_CREAD: begin
        state_next = S_CEMIT;
      end
      S_CEMIT: begin
        cmd.emit_sel = EMIT_CHAR;
        if (sts.emit_ok) begin
          cmd.emit   = 1'b1;
          state_next = sts.kchar_last ? S_GAP : S_CREAD;
        end
      end
      S_GAP: begin
        cmd.load_spc = 1'b1;
        if (!sts.spc_calc_zero) begin
          state_next = S_SEMIT;
        end else if (sts.word_last) begin
          state_next = S_NL;
        end else begin
          cmd.next_word = 1'b1;
          state_next    = S_WREAD;
        end
      end
      S_SEMIT: begin
        cmd.emit_sel = EMIT_SPACE;
        if (sts.emit_ok) begin
          cmd.emit = 1'b1;
          if (sts.spc_last) begin
            if (sts.word_last) begin
              state_next = S_NL;
            end else begin
              cmd.next_word = 1'b1;
              state_next    = S_WREAD;
            end
          end
        end
      end
      S_NL: begin
        cmd.emit_sel = EMIT_NL;
        // a line flushed ahead of the word that overflowed it is not the
        // last one when the final flush still follows
        cmd.nl_final = !(mode_add && sts.is_end);
        if (sts.emit_ok) begin
          cmd.emit       = 1'b1;
          cmd.flush_done = 1'b1;
          state_next     = mode_add ? S_ADD : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode_add <= 1'b0;
    end else begin
      state    <= state_next;
      mode_add <= mode_add_next;
    end
  end

endmodule

[rtl/core/greedy_line_justifier_core.sv]
// Greedy line justifier.
// Input channel: in_char / end_of_text beats, taken when in_valid is high and
// in_stall is low. Byte 32 separates words, byte 0 is ignored, end_of_text
// closes the paragraph and flushes the held line.
// Output channel: out_char / run_last beats, taken when out_valid is high and
// out_stall is low. run_last marks the final byte caused by one input beat.
// Config: cfg_wr_en writes cfg_wr_data into the line length (reset 31); write
// only while the block is idle.
// Sequencing: a word byte passes the idle and char states; a separator that only
// closes a word also passes the close and add states. A line flush runs a setup
// state, a gap division (lines with more than one word), a length read and gap
// setup per word, a read and emit per word byte, set by the registered read of
// the line buffer, and an emit per space and for the newline.
// in_stall stays high until every byte of the current beat is in the output
// register. A stall on the output pauses the flush walk; only bytes past MAX_RESULTS for one beat are dropped.
// The output register lets the next input beat in while the last byte waits.
// Reset: synchronous; clears the held line, the open word and the output
// register and restores the line length to 31. No memory clearing pass.
module greedy_line_justifier_core import glj_pkg::*; #(
  parameter int WORD_MAX = 17,
  parameter int LINE_MAX = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_char,
  input  logic             end_of_text,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_char,
  output logic             run_last
);

  cmd_t cmd;
  sts_t sts;

  glj_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  glj_dp #(.WORD_MAX(WORD_MAX), .LINE_MAX(LINE_MAX)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_char     (in_char),
    .end_of_text (end_of_text),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_char    (out_char),
    .run_last    (run_last)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted beat did not make the block busy");

  a_emit_into_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.emit_ok)
    else $error("byte emitted while output register is blocked");

  a_flush_has_words: assert property (@(posedge clk) disable iff (rst)
    cmd.fsetup |-> !sts.held_zero)
    else $error("flush walk started on an empty line");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_in, cmd.char_step, cmd.add_word, cmd.fsetup, cmd.emit}))
    else $error("conflicting datapath commands");

endmodule

[verif/tb_top.sv]
module tb_top;
  import glj_pkg::*;

  localparam int WORD_MAX = 17;
  localparam int LINE_MAX = 31;
  localparam int TEXT_DEPTH = LINE_MAX + WORD_MAX;
  localparam int LEN_DEPTH = LINE_MAX / 2 + 2;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_char = NUL_BYTE;
  logic end_of_text = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_char;
  logic run_last;

  greedy_line_justifier_core #(
    .WORD_MAX(WORD_MAX),
    .LINE_MAX(LINE_MAX)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char(in_char),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char(out_char),
    .run_last(run_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------- justifier prediction ----------------
  logic [7:0] text_mem [0:TEXT_DEPTH-1];
  logic [4:0] word_len [0:LEN_DEPTH-1];
  int unsigned n_held = 0;
  int unsigned held_len = 0;
  int unsigned open_len = 0;
  logic [LEN_W-1:0] width_cfg = LEN_RESET;

  logic [7:0] step_bytes[$];
  out_beat_t justified_q[$];
  text_beat_t text_q[$];

  int unsigned errors = 0;

  function automatic int unsigned line_width();
    return (int'(width_cfg) > LINE_MAX) ? LINE_MAX : int'(width_cfg);
  endfunction

  function automatic void put_byte(logic [7:0] b);
    if (step_bytes.size() < MAX_RESULTS)
      step_bytes.push_back(b);
  endfunction

  function automatic void put_spaces(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      put_byte(SEP_BYTE);
  endfunction

  function automatic void emit_held_line();
    int unsigned len, pos, gaps, slack, base, extra;
    len = line_width();
    pos = 0;
    slack = 0;
    base = 0;
    extra = 0;
    if (n_held == 0)
      return;
    gaps = n_held - 1;
    if (len > held_len)
      slack = len - held_len;
    if (gaps > 0) begin
      base = slack / gaps;
      extra = slack % gaps;
    end
    for (int unsigned w = 0; w < n_held && w < LEN_DEPTH; w++) begin
      for (int unsigned k = 0; k < word_len[w]; k++) begin
        if (pos < TEXT_DEPTH)
          put_byte(text_mem[pos]);
        pos++;
      end
      if (gaps > 0 && w < gaps)
        put_spaces(base + ((w < extra) ? 1 : 0));
    end
    if (gaps == 0)
      put_spaces(slack);
    put_byte(NL_BYTE);
    n_held = 0;
    held_len = 0;
  endfunction

  function automatic void close_open_word();
    int unsigned wl, from;
    wl = open_len;
    if (wl == 0)
      return;
    if (n_held > 0 && held_len + n_held + wl > line_width()) begin
      from = held_len;
      emit_held_line();
      // open word slides down to the start of the new line
      if (from + wl <= TEXT_DEPTH)
        for (int unsigned i = 0; i < wl; i++)
          text_mem[i] = text_mem[from + i];
    end
    if (n_held < LEN_DEPTH) begin
      word_len[n_held] = wl[4:0];
      n_held++;
      held_len += wl;
    end
    open_len = 0;
  endfunction

  function automatic void justify_beat(logic [7:0] c, logic eot);
    int unsigned p;
    step_bytes.delete();
    if (c == SEP_BYTE) begin
      close_open_word();
    end else if (c != NUL_BYTE) begin
      if (open_len < WORD_MAX) begin
        p = held_len + open_len;
        if (p < TEXT_DEPTH) begin
          text_mem[p] = c;
          open_len++;
        end
      end
    end
    if (eot) begin
      close_open_word();
      emit_held_line();
      n_held = 0;
      held_len = 0;
      open_len = 0;
    end
    for (int i = 0; i < step_bytes.size(); i++)
      justified_q.push_back('{ch: step_bytes[i], last: (i == step_bytes.size() - 1)});
  endfunction

  task automatic flag(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // mostly short gaps, a few long, with calm stretches of no gaps
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = 30;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------- input driver ----------------
  int unsigned gap_in = 0;
  int unsigned calm_in = 0;
  text_beat_t next_beat;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        justify_beat(in_char, end_of_text);
      if (!in_valid || !in_stall) begin
        if (gap_in > 0 || text_q.size() == 0) begin
          if (gap_in > 0)
            gap_in--;
          in_valid <= 1'b0;
        end else begin
          next_beat = text_q.pop_front();
          in_char <= next_beat.ch;
          end_of_text <= next_beat.eot;
          in_valid <= 1'b1;
          gap_in = pick_gap(calm_in);
        end
      end
    end
  end

  // ---------------- output monitor ----------------
  int unsigned stall_left = 0;
  int unsigned calm_out = 0;
  int unsigned long_hold = 0;
  int unsigned out_seen = 0;
  bit long_done = 0;
  out_beat_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      out_seen++;
      if (justified_q.size() == 0) begin
        flag($sformatf("unexpected beat char=%02h last=%b", out_char, run_last));
      end else begin
        want = justified_q.pop_front();
        if (out_char !== want.ch)
          flag($sformatf("out_char %02h, expected %02h", out_char, want.ch));
        if (run_last !== want.last)
          flag($sformatf("run_last %b, expected %b (char %02h)", run_last, want.last,
                         want.ch));
      end
    end
    if (long_hold > 0) begin
      long_hold--;
      out_stall <= 1'b1;
    end else if (!long_done && out_seen >= 60 && text_q.size() > 10) begin
      // long hold-off while the sender keeps offering: block must back up
      long_done = 1;
      long_hold = 400;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap(calm_out);
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic [7:0] word_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(1, 255)); while (v == SEP_BYTE);
    return v;
  endfunction

  function automatic void push_text(logic [7:0] c, logic eot);
    text_q.push_back('{ch: c, eot: eot});
  endfunction

  function automatic void maybe_null();
    if ($urandom_range(0, 19) == 0)
      push_text(NUL_BYTE, 1'b0);
  endfunction

  // returns number of beats added
  function automatic int unsigned add_paragraph();
    int unsigned n0, nwords, wl, r, ending;
    n0 = text_q.size();
    if ($urandom_range(0, 9) == 0) begin
      // noise: arbitrary bytes, end flag rare
      repeat ($urandom_range(1, 5))
        push_text(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      return text_q.size() - n0;
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2)) push_text(SEP_BYTE, 1'b0);
    nwords = $urandom_range(1, 6);
    ending = $urandom_range(0, 2);
    for (int unsigned w = 0; w < nwords; w++) begin
      r = $urandom_range(0, 99);
      wl = (r < 80) ? $urandom_range(1, 6) : (r < 95) ? $urandom_range(7, 12)
                                                     : $urandom_range(13, 20);
      for (int unsigned k = 0; k < wl; k++) begin
        maybe_null();
        push_text(word_byte(), (ending == 0) && (w == nwords - 1) && (k == wl - 1));
      end
      if (w != nwords - 1) begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(2, 3)) push_text(SEP_BYTE, 1'b0);
        else
          push_text(SEP_BYTE, 1'b0);
      end
    end
    if (ending == 1)
      push_text(SEP_BYTE, 1'b1);
    else if (ending == 2)
      push_text(NUL_BYTE, 1'b1);
    return text_q.size() - n0;
  endfunction

  task automatic wait_drained();
    while (text_q.size() != 0 || in_valid || justified_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_width(logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    width_cfg = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  logic [LEN_W-1:0] widths [0:6];
  int unsigned added;

  initial begin
    widths[0] = 5'd0;
    widths[1] = 5'd1;
    widths[2] = 5'd3;
    widths[3] = 5'd8;
    widths[4] = 5'd17;
    widths[5] = 5'd31;
    widths[6] = 5'($urandom_range(2, 30));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: separator runs, edge byte values, newline as a word byte,
    // null with end flag, empty text, long word truncation
    push_text(SEP_BYTE, 1'b0);
    push_text(8'hFF, 1'b0);
    push_text(NL_BYTE, 1'b0);
    push_text(SEP_BYTE, 1'b0);
    push_text(SEP_BYTE, 1'b0);
    push_text(8'h01, 1'b0);
    push_text(NUL_BYTE, 1'b1);
    push_text(SEP_BYTE, 1'b1);
    for (int i = 0; i < 18; i++)
      push_text(8'h41 + 8'(i), i == 17);
    wait_drained();
    repeat (20) @(negedge clk);

    foreach (widths[p]) begin
      set_width(widths[p]);
      @(negedge clk);
      if (widths[p] == 5'd3) begin
        // over-long word alone on a line
        for (int i = 0; i < 6; i++)
          push_text(word_byte(), i == 5);
      end
      added = 0;
      while (added < 10)
        added += add_paragraph();
      push_text(NUL_BYTE, 1'b1);
      wait_drained();
      repeat (20) @(negedge clk);
    end

    wait_drained();
    repeat (50) @(negedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #100000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
